// ===== hw/rtl/jpa_pkg.sv =====
// Shared types and constants for the joystick port with autofire.
// No dependencies; used by jpa_core and joystick_port_with_autofire.
package jpa_pkg;

   // Default width of the frame counter compare and shot schedule.
   localparam int FRAME_BITS_DEFAULT = 32;

   // Fixed field widths.
   localparam int FRAME_IN_W = 32;
   localparam int CODE_W     = 4;
   localparam int BULLETS_W  = 8;
   localparam int DELAY_W    = 16;
   localparam int PORT_W     = 2;
   localparam int SHOTS_W    = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Request kinds.
   localparam logic REQ_EVENT = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   // Gamepad event codes.
   localparam logic [CODE_W-1:0] EV_UP           = 4'd0;
   localparam logic [CODE_W-1:0] EV_DOWN         = 4'd1;
   localparam logic [CODE_W-1:0] EV_LEFT         = 4'd2;
   localparam logic [CODE_W-1:0] EV_RIGHT        = 4'd3;
   localparam logic [CODE_W-1:0] EV_RELEASE_X    = 4'd4;
   localparam logic [CODE_W-1:0] EV_RELEASE_Y    = 4'd5;
   localparam logic [CODE_W-1:0] EV_RELEASE_XY   = 4'd6;
   localparam logic [CODE_W-1:0] EV_PRESS_FIRE   = 4'd7;
   localparam logic [CODE_W-1:0] EV_RELEASE_FIRE = 4'd8;

   // Config register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_AF_ENABLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AF_BULLETS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AF_DELAY   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_SEL   = 2'd3;

   // Config reset values.
   localparam logic                        AF_ENABLE_RST  = 1'b0;
   localparam logic signed [BULLETS_W-1:0] AF_BULLETS_RST = -8'sd3;
   localparam logic signed [DELAY_W-1:0]   AF_DELAY_RST   = 16'sd125;
   localparam logic [PORT_W-1:0]           PORT_SEL_RST   = 2'd1;
   localparam logic [PORT_W-1:0]           PORT_ONE       = 2'd1;

   // Axis direction codes (two's complement -1, 0, +1).
   localparam logic [1:0] DIR_NEG  = 2'b11;
   localparam logic [1:0] DIR_ZERO = 2'b00;
   localparam logic [1:0] DIR_POS  = 2'b01;

   // Data word and fire byte constants.
   localparam logic [15:0] WORD_LEFT  = 16'h0300;
   localparam logic [15:0] WORD_RIGHT = 16'h0003;
   localparam logic [15:0] WORD_UP    = 16'h0100;
   localparam logic [15:0] WORD_DOWN  = 16'h0001;
   localparam logic [7:0]  FIRE_PORT1 = 8'hBF;
   localparam logic [7:0]  FIRE_PORT2 = 8'h7F;
   localparam logic [7:0]  FIRE_IDLE  = 8'hFF;

   // Port-visible state after a request.
   typedef struct packed {
      logic              fire;
      logic [1:0]        x_dir;
      logic [1:0]        y_dir;
      logic [PORT_W-1:0] port_sel;
   } jpa_state_type;

endpackage

// ===== hw/rtl/jpa_core.sv =====
// Joystick state, autofire magazine and config registers.
// Depends on jpa_pkg. Next-state logic is one short pass per request.
module jpa_core #(
   parameter int FRAME_BITS = jpa_pkg::FRAME_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             item_accept,
   input  logic                             req_type,
   input  logic [jpa_pkg::CODE_W-1:0]       req_event_code,
   input  logic [jpa_pkg::FRAME_IN_W-1:0]   req_frame_number,
   input  logic                             csr_write_enable,
   input  logic [jpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jpa_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output jpa_pkg::jpa_state_type           state_next
);

   logic                                     af_enable_ff,  af_enable_in;
   logic signed [jpa_pkg::BULLETS_W-1:0]     af_bullets_ff, af_bullets_in;
   logic signed [jpa_pkg::DELAY_W-1:0]       af_delay_ff,   af_delay_in;
   logic [jpa_pkg::PORT_W-1:0]               port_sel_ff,   port_sel_in;
   logic                                     fire_ff,       fire_in;
   logic [1:0]                               x_dir_ff,      x_dir_in;
   logic [1:0]                               y_dir_ff,      y_dir_in;
   logic [jpa_pkg::SHOTS_W-1:0]              shots_left_ff, shots_left_in;
   logic                                     shots_unl_ff,  shots_unl_in;
   logic [FRAME_BITS-1:0]                    next_shot_ff,  next_shot_in;

   logic                                     mag_active;
   logic [FRAME_BITS-1:0]                    frame;
   logic [FRAME_BITS-1:0]                    shot_frame;
   logic signed [jpa_pkg::BULLETS_W-1:0]     csr_bullets;

   assign mag_active  = shots_unl_ff || (shots_left_ff != '0);
   assign frame       = FRAME_BITS'(req_frame_number);
   // frame + sign-extended delay, wraps at the frame width
   assign shot_frame  = frame + FRAME_BITS'(af_delay_ff);
   assign csr_bullets = signed'(csr_write_data[jpa_pkg::BULLETS_W-1:0]);

   always_comb begin
      af_enable_in  = af_enable_ff;
      af_bullets_in = af_bullets_ff;
      af_delay_in   = af_delay_ff;
      port_sel_in   = port_sel_ff;
      fire_in       = fire_ff;
      x_dir_in      = x_dir_ff;
      y_dir_in      = y_dir_ff;
      shots_left_in = shots_left_ff;
      shots_unl_in  = shots_unl_ff;
      next_shot_in  = next_shot_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            jpa_pkg::CSR_AF_ENABLE: begin
               if (csr_write_data[0] != af_enable_ff) begin
                  af_enable_in = csr_write_data[0];
                  if (!csr_write_data[0]) fire_in = 1'b0;
               end
            end
            jpa_pkg::CSR_AF_BULLETS: begin
               if (csr_bullets != af_bullets_ff) begin
                  af_bullets_in = csr_bullets;
                  if (mag_active) begin
                     shots_unl_in  = csr_bullets[jpa_pkg::BULLETS_W-1];
                     shots_left_in = csr_bullets[jpa_pkg::BULLETS_W-1] ? '0
                                     : csr_bullets[jpa_pkg::SHOTS_W-1:0];
                  end
               end
            end
            jpa_pkg::CSR_AF_DELAY: af_delay_in = signed'(csr_write_data);
            jpa_pkg::CSR_PORT_SEL: port_sel_in = csr_write_data[jpa_pkg::PORT_W-1:0];
            default: ;
         endcase
      end else if (item_accept) begin
         if (req_type == jpa_pkg::REQ_TICK) begin
            if (af_enable_ff && !af_delay_ff[jpa_pkg::DELAY_W-1] &&
                frame == next_shot_ff && mag_active) begin
               fire_in = !fire_ff;
               // a release spends one shot
               if (fire_ff && !shots_unl_ff) shots_left_in = shots_left_ff - 1'b1;
               next_shot_in = shot_frame;
            end
         end else begin
            unique case (req_event_code)
               jpa_pkg::EV_UP:         y_dir_in = jpa_pkg::DIR_NEG;
               jpa_pkg::EV_DOWN:       y_dir_in = jpa_pkg::DIR_POS;
               jpa_pkg::EV_LEFT:       x_dir_in = jpa_pkg::DIR_NEG;
               jpa_pkg::EV_RIGHT:      x_dir_in = jpa_pkg::DIR_POS;
               jpa_pkg::EV_RELEASE_X:  x_dir_in = jpa_pkg::DIR_ZERO;
               jpa_pkg::EV_RELEASE_Y:  y_dir_in = jpa_pkg::DIR_ZERO;
               jpa_pkg::EV_RELEASE_XY: begin
                  x_dir_in = jpa_pkg::DIR_ZERO;
                  y_dir_in = jpa_pkg::DIR_ZERO;
               end
               jpa_pkg::EV_PRESS_FIRE: begin
                  if (!af_enable_ff) begin
                     fire_in = 1'b1;
                  end else if (mag_active) begin
                     // second press empties the magazine
                     shots_left_in = '0;
                     shots_unl_in  = 1'b0;
                     fire_in       = 1'b0;
                  end else begin
                     fire_in       = 1'b1;
                     shots_unl_in  = af_bullets_ff[jpa_pkg::BULLETS_W-1];
                     shots_left_in = af_bullets_ff[jpa_pkg::BULLETS_W-1] ? '0
                                     : af_bullets_ff[jpa_pkg::SHOTS_W-1:0];
                     next_shot_in  = shot_frame;
                  end
               end
               jpa_pkg::EV_RELEASE_FIRE: begin
                  if (!af_enable_ff) fire_in = 1'b0;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         af_enable_ff  <= jpa_pkg::AF_ENABLE_RST;
         af_bullets_ff <= jpa_pkg::AF_BULLETS_RST;
         af_delay_ff   <= jpa_pkg::AF_DELAY_RST;
         port_sel_ff   <= jpa_pkg::PORT_SEL_RST;
         fire_ff       <= 1'b0;
         x_dir_ff      <= jpa_pkg::DIR_ZERO;
         y_dir_ff      <= jpa_pkg::DIR_ZERO;
         shots_left_ff <= '0;
         shots_unl_ff  <= 1'b0;
         next_shot_ff  <= '0;
      end else begin
         af_enable_ff  <= af_enable_in;
         af_bullets_ff <= af_bullets_in;
         af_delay_ff   <= af_delay_in;
         port_sel_ff   <= port_sel_in;
         fire_ff       <= fire_in;
         x_dir_ff      <= x_dir_in;
         y_dir_ff      <= y_dir_in;
         shots_left_ff <= shots_left_in;
         shots_unl_ff  <= shots_unl_in;
         next_shot_ff  <= next_shot_in;
      end
   end

   assign state_next.fire     = fire_in;
   assign state_next.x_dir    = x_dir_in;
   assign state_next.y_dir    = y_dir_in;
   assign state_next.port_sel = port_sel_ff;

endmodule

// ===== hw/rtl/joystick_port_with_autofire.sv =====
// Top level: joystick port with autofire, request/response handshake and
// output encoding. Depends on jpa_pkg and jpa_core.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------
//   req     | in        | req_valid/req_stall | req_type, req_event_code,
//           |           |                     | req_frame_number
//   rsp     | out       | rsp_valid/rsp_stall | rsp_joy_data_word, rsp_port_fire_byte,
//           |           |                     | rsp_fire_pressed
//   csr     | in        | csr_write_enable    | csr_index, csr_write_data
//
// One request per cycle while req_stall is low; each response appears in the
// cycle after its request is accepted. The joystick state updates in the accept
// cycle and the encoded result lands in the response register.
// req_stall is high only while a response is held and rsp_stall is high;
// when the response drains, a new request is taken in the same cycle.
// Synchronous active-high reset loads config defaults and clears all but the payload registers.
module joystick_port_with_autofire #(
   parameter int FRAME_BITS = jpa_pkg::FRAME_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [jpa_pkg::CODE_W-1:0]       req_event_code,
   input  logic [jpa_pkg::FRAME_IN_W-1:0]   req_frame_number,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [15:0]                      rsp_joy_data_word,
   output logic [7:0]                       rsp_port_fire_byte,
   output logic                             rsp_fire_pressed,
   // config write port
   input  logic                             csr_write_enable,
   input  logic [jpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jpa_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   jpa_pkg::jpa_state_type state_next;

   logic        item_accept;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] word_ff,      word_in;
   logic [7:0]  fire_byte_ff, fire_byte_in;
   logic        fire_ff,      fire_in;

   // stall only while a response is parked and downstream is not taking it
   assign req_stall   = rsp_valid_ff && rsp_stall;
   assign item_accept = req_valid && !req_stall;

   jpa_core #(
      .FRAME_BITS (FRAME_BITS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .item_accept      (item_accept),
      .req_type         (req_type),
      .req_event_code   (req_event_code),
      .req_frame_number (req_frame_number),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .state_next       (state_next)
   );

   // data word: X sets both bits of a pair, Y flips one of them
   always_comb begin
      word_in = '0;
      if (state_next.x_dir == jpa_pkg::DIR_NEG)      word_in = jpa_pkg::WORD_LEFT;
      else if (state_next.x_dir == jpa_pkg::DIR_POS) word_in = jpa_pkg::WORD_RIGHT;
      if (state_next.y_dir == jpa_pkg::DIR_NEG)      word_in = word_in ^ jpa_pkg::WORD_UP;
      else if (state_next.y_dir == jpa_pkg::DIR_POS) word_in = word_in ^ jpa_pkg::WORD_DOWN;
   end

   // active-low fire byte; port 1 uses bit 6, anything else bit 7
   assign fire_byte_in = !state_next.fire ? jpa_pkg::FIRE_IDLE
                       : (state_next.port_sel == jpa_pkg::PORT_ONE) ? jpa_pkg::FIRE_PORT1
                       : jpa_pkg::FIRE_PORT2;
   assign fire_in      = state_next.fire;

   assign rsp_valid_in = item_accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload register, loaded only on accept so a stalled response holds
   always_ff @(posedge clock) begin
      if (item_accept) begin
         word_ff      <= word_in;
         fire_byte_ff <= fire_byte_in;
         fire_ff      <= fire_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_joy_data_word  = word_ff;
   assign rsp_port_fire_byte = fire_byte_ff;
   assign rsp_fire_pressed   = fire_ff;

endmodule

// ===== verif/joystick_port_with_autofire_tb.sv =====
// Testbench for joystick_port_with_autofire: a directed request table, then random
// autofire phases; in-order response checks against pins or an in-bench predictor.
// Depends on jpa_pkg and the joystick_port_with_autofire RTL.
module joystick_port_with_autofire_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import jpa_pkg::*;

   // Highest event code; everything above EV_RELEASE_FIRE is a no-op.
   localparam logic [CODE_W-1:0] EV_UNUSED_MAX = 4'd15;

   // What one response carries.
   typedef struct packed {
      logic [15:0] word;
      logic [7:0]  fire_byte;
      logic        pressed;
   } joy_result_type;

   // One line of the directed script: either a register write or a request,
   // the latter optionally with its response typed in by hand.
   typedef struct packed {
      logic                  is_write;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      logic                  kind;
      logic [CODE_W-1:0]     code;
      logic [FRAME_IN_W-1:0] frame;
      logic                  pinned;
      joy_result_type        want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_type;
   logic [CODE_W-1:0]     req_event_code;
   logic [FRAME_IN_W-1:0] req_frame_number;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [15:0]           rsp_joy_data_word;
   logic [7:0]            rsp_port_fire_byte;
   logic                  rsp_fire_pressed;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   joystick_port_with_autofire dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_event_code     (req_event_code),
      .req_frame_number   (req_frame_number),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_joy_data_word  (rsp_joy_data_word),
      .rsp_port_fire_byte (rsp_port_fire_byte),
      .rsp_fire_pressed   (rsp_fire_pressed),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor copy of the port: config registers and joystick state.
   // ---------------------------------------------------------------------
   logic                     af_on;
   logic signed [BULLETS_W-1:0] mag_size;
   logic signed [DELAY_W-1:0]   toggle_delay;
   logic [PORT_W-1:0]        port_num;
   logic                     btn;
   logic [1:0]               x_dir;
   logic [1:0]               y_dir;
   logic [SHOTS_W-1:0]       shots_left;
   logic                     unlimited;
   logic [FRAME_IN_W-1:0]    next_shot;

   joy_result_type readings_due[$];   // responses owed by the DUT, oldest first
   int             mismatch_count = 0;

   // Response pinned by the directed script for the request now on offer.
   logic           pin_on;
   joy_result_type pin_val;

   // Set by the stimulus to ask the response side for one long hold-off.
   logic        hold_rsp_req;

   function automatic logic magazine_loaded();
      return unlimited || (shots_left != '0);
   endfunction

   function automatic void reload_magazine();
      if (mag_size < 0) begin
         unlimited  = 1'b1;
         shots_left = '0;
      end else begin
         unlimited  = 1'b0;
         shots_left = mag_size[SHOTS_W-1:0];
      end
   endfunction

   // Delay is signed; the sum wraps with the frame counter.
   function automatic logic [FRAME_IN_W-1:0] shot_after(input logic [FRAME_IN_W-1:0] frame);
      return frame + FRAME_IN_W'(toggle_delay);
   endfunction

   function automatic void apply_register_write(input logic [CSR_IDX_W-1:0] idx,
                                                input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_AF_ENABLE: begin
            // rewriting the same value has no side effect
            if (val[0] != af_on) begin
               af_on = val[0];
               if (!val[0]) btn = 1'b0;
            end
         end
         CSR_AF_BULLETS: begin
            if (val[BULLETS_W-1:0] != mag_size) begin
               mag_size = val[BULLETS_W-1:0];
               if (magazine_loaded()) reload_magazine();
            end
         end
         CSR_AF_DELAY: toggle_delay = val[DELAY_W-1:0];
         default:      port_num = val[PORT_W-1:0];
      endcase
   endfunction

   // Advances the joystick state by one accepted request and encodes the port.
   function automatic joy_result_type predict_reading(input logic kind,
                                                      input logic [CODE_W-1:0] code,
                                                      input logic [FRAME_IN_W-1:0] frame);
      joy_result_type r;
      if (kind == REQ_TICK) begin
         if (af_on && !toggle_delay[DELAY_W-1] && frame == next_shot && magazine_loaded()) begin
            if (btn) begin
               btn = 1'b0;
               if (!unlimited) shots_left = shots_left - 1'b1;
            end else begin
               btn = 1'b1;
            end
            next_shot = shot_after(frame);
         end
      end else begin
         case (code)
            EV_UP:         y_dir = DIR_NEG;
            EV_DOWN:       y_dir = DIR_POS;
            EV_LEFT:       x_dir = DIR_NEG;
            EV_RIGHT:      x_dir = DIR_POS;
            EV_RELEASE_X:  x_dir = DIR_ZERO;
            EV_RELEASE_Y:  y_dir = DIR_ZERO;
            EV_RELEASE_XY: begin
               x_dir = DIR_ZERO;
               y_dir = DIR_ZERO;
            end
            EV_PRESS_FIRE: begin
               if (!af_on) begin
                  btn = 1'b1;
               end else if (magazine_loaded()) begin
                  // second press empties the magazine
                  shots_left = '0;
                  unlimited  = 1'b0;
                  btn        = 1'b0;
               end else begin
                  btn = 1'b1;
                  reload_magazine();
                  next_shot = shot_after(frame);
               end
            end
            EV_RELEASE_FIRE: if (!af_on) btn = 1'b0;
            default: ;
         endcase
      end
      r.word = 16'h0000;
      if (x_dir == DIR_NEG)      r.word = WORD_LEFT;
      else if (x_dir == DIR_POS) r.word = WORD_RIGHT;
      if (y_dir == DIR_NEG)      r.word = r.word ^ WORD_UP;
      else if (y_dir == DIR_POS) r.word = r.word ^ WORD_DOWN;
      r.fire_byte = !btn ? FIRE_IDLE : (port_num == PORT_ONE ? FIRE_PORT1 : FIRE_PORT2);
      r.pressed   = btn;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: everything sampled at the rising edge, before the DUT's own
   // updates land. Responses are checked first, then the accepted request
   // is predicted, then a register write is mirrored.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      joy_result_type got;
      joy_result_type want;
      if (reset) begin
         af_on        = AF_ENABLE_RST;
         mag_size     = AF_BULLETS_RST;
         toggle_delay = AF_DELAY_RST;
         port_num     = PORT_SEL_RST;
         btn          = 1'b0;
         x_dir        = DIR_ZERO;
         y_dir        = DIR_ZERO;
         shots_left   = '0;
         unlimited    = 1'b0;
         next_shot    = '0;
         readings_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (readings_due.size() == 0) begin
               $error("response with no request outstanding");
               mismatch_count++;
            end else begin
               want = readings_due.pop_front();
               if (rsp_joy_data_word !== want.word) begin
                  $error("rsp_joy_data_word: expected %h, got %h", want.word, rsp_joy_data_word);
                  mismatch_count++;
               end
               if (rsp_port_fire_byte !== want.fire_byte) begin
                  $error("rsp_port_fire_byte: expected %h, got %h",
                         want.fire_byte, rsp_port_fire_byte);
                  mismatch_count++;
               end
               if (rsp_fire_pressed !== want.pressed) begin
                  $error("rsp_fire_pressed: expected %b, got %b", want.pressed, rsp_fire_pressed);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            // pinned rows still advance the predictor state
            got = predict_reading(req_type, req_event_code, req_frame_number);
            readings_due.push_back(pin_on ? pin_val : got);
         end
         if (csr_write_enable) apply_register_write(csr_index, csr_write_data);
      end
   end

   // ---------------------------------------------------------------------
   // Response side: stretches of no stall, light, medium and heavy random
   // stall, plus one long hold on demand so the DUT backs up into req_stall.
   // ---------------------------------------------------------------------
   initial begin
      int   len;
      int   mode;
      logic hold_done;
      rsp_stall = 1'b0;
      hold_done = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (60) @(negedge clock);
         end else begin
            len  = $urandom_range(1, 40);
            mode = $urandom_range(0, 3);
            for (int k = 0; k < len && !(hold_rsp_req && !hold_done); k++) begin
               case (mode)
                  0:       rsp_stall <= 1'b0;
                  1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                  2:       rsp_stall <= 1'($urandom_range(0, 1));
                  default: rsp_stall <= ($urandom_range(0, 3) != 0);
               endcase
               @(negedge clock);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side helpers. All called and returning at a falling edge.
   // ---------------------------------------------------------------------
   task automatic send_request(input logic kind, input logic [CODE_W-1:0] code,
                               input logic [FRAME_IN_W-1:0] frame,
                               input logic pinned, input joy_result_type want);
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_event_code   <= code;
      req_frame_number <= frame;
      pin_on  = pinned;
      pin_val = want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering and wait until every owed response has been taken.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (readings_due.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   function automatic stim_row_type req_row(input logic kind, input logic [CODE_W-1:0] code,
                                            input logic [FRAME_IN_W-1:0] frame);
      stim_row_type s;
      s        = '0;
      s.kind   = kind;
      s.code   = code;
      s.frame  = frame;
      return s;
   endfunction

   function automatic stim_row_type pin_row(input logic kind, input logic [CODE_W-1:0] code,
                                            input logic [FRAME_IN_W-1:0] frame,
                                            input logic [15:0] word, input logic [7:0] fbyte,
                                            input logic pressed);
      stim_row_type s;
      s        = req_row(kind, code, frame);
      s.pinned = 1'b1;
      s.want   = '{word: word, fire_byte: fbyte, pressed: pressed};
      return s;
   endfunction

   function automatic stim_row_type wr_row(input logic [CSR_IDX_W-1:0] idx,
                                           input logic [CSR_DATA_W-1:0] val);
      stim_row_type s;
      s          = '0;
      s.is_write = 1'b1;
      s.reg_idx  = idx;
      s.reg_val  = val;
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      stim_row_type          script[$];
      int                    roll;
      int                    gap;
      int                    burst_left;
      int                    pressure_left;
      logic                  kind;
      logic [CODE_W-1:0]     code;
      logic [FRAME_IN_W-1:0] cur_frame;
      logic [FRAME_IN_W-1:0] frame;
      logic                  en;
      logic [BULLETS_W-1:0]  bul;
      logic [DELAY_W-1:0]    dly;
      logic [PORT_W-1:0]     prt;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = REQ_EVENT;
      req_event_code   = EV_UP;
      req_frame_number = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_AF_ENABLE;
      csr_write_data   = '0;
      pin_on           = 1'b0;
      pin_val          = '0;
      hold_rsp_req     = 1'b0;
      burst_left       = 0;
      pressure_left    = 0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Axis rows skip only the RELEASE_Y code and show the XOR
      // encoding (right plus down cancels to 0x0002); then plain fire, an
      // unknown code, a tick with autofire off, both fire ports including the
      // out-of-range port value, and an autofire magazine run: shots spent,
      // release ignored, empty magazine stops ticking, press-to-cancel,
      // unlimited magazine across the frame wrap, reload on a new count, and
      // autofire switched off while the button is down.
      script.push_back(pin_row(REQ_EVENT, EV_UP,         '0,            16'h0100, FIRE_IDLE, 1'b0));
      script.push_back(pin_row(REQ_EVENT, EV_DOWN,       32'hFFFF_FFFF, 16'h0001, FIRE_IDLE, 1'b0));
      script.push_back(pin_row(REQ_EVENT, EV_LEFT,       '0,            16'h0301, FIRE_IDLE, 1'b0));
      script.push_back(pin_row(REQ_EVENT, EV_RIGHT,      '0,            16'h0002, FIRE_IDLE, 1'b0));
      script.push_back(pin_row(REQ_EVENT, EV_UP,         '0,            16'h0103, FIRE_IDLE, 1'b0));
      script.push_back(pin_row(REQ_EVENT, EV_RELEASE_X,  '0,            16'h0100, FIRE_IDLE, 1'b0));
      script.push_back(pin_row(REQ_EVENT, EV_RELEASE_XY, '0,            16'h0000, FIRE_IDLE, 1'b0));
      script.push_back(pin_row(REQ_EVENT, EV_PRESS_FIRE, '0,            16'h0000, FIRE_PORT1, 1'b1));
      script.push_back(pin_row(REQ_EVENT, EV_UNUSED_MAX, '0,            16'h0000, FIRE_PORT1, 1'b1));
      script.push_back(pin_row(REQ_TICK,  EV_LEFT,       '0,            16'h0000, FIRE_PORT1, 1'b1));
      script.push_back(pin_row(REQ_EVENT, EV_RELEASE_FIRE, '0,          16'h0000, FIRE_IDLE, 1'b0));
      script.push_back(wr_row(CSR_PORT_SEL, 16'h0002));
      script.push_back(pin_row(REQ_EVENT, EV_PRESS_FIRE, '0,            16'h0000, FIRE_PORT2, 1'b1));
      script.push_back(wr_row(CSR_PORT_SEL, 16'h0003));
      script.push_back(pin_row(REQ_TICK,  EV_UP,         32'd5,         16'h0000, FIRE_PORT2, 1'b1));
      script.push_back(wr_row(CSR_PORT_SEL, 16'h0001));
      script.push_back(pin_row(REQ_EVENT, EV_RELEASE_FIRE, '0,          16'h0000, FIRE_IDLE, 1'b0));
      script.push_back(wr_row(CSR_AF_ENABLE,  16'h0001));
      script.push_back(wr_row(CSR_AF_DELAY,   16'h0002));
      script.push_back(wr_row(CSR_AF_BULLETS, 16'h0002));
      script.push_back(req_row(REQ_EVENT, EV_PRESS_FIRE,   32'd100));
      script.push_back(req_row(REQ_TICK,  EV_UP,           32'd102));
      script.push_back(req_row(REQ_TICK,  EV_UP,           32'd104));
      script.push_back(req_row(REQ_EVENT, EV_RELEASE_FIRE, 32'd105));
      script.push_back(req_row(REQ_TICK,  EV_UP,           32'd106));
      script.push_back(req_row(REQ_TICK,  EV_UP,           32'd108));
      script.push_back(req_row(REQ_EVENT, EV_PRESS_FIRE,   32'd200));
      script.push_back(req_row(REQ_EVENT, EV_PRESS_FIRE,   32'd201));
      script.push_back(wr_row(CSR_AF_BULLETS, 16'hFFFF));
      script.push_back(req_row(REQ_EVENT, EV_PRESS_FIRE,   32'hFFFF_FFFF));
      script.push_back(req_row(REQ_TICK,  EV_UP,           32'd1));
      script.push_back(req_row(REQ_TICK,  EV_UP,           32'd3));
      script.push_back(wr_row(CSR_AF_BULLETS, 16'h0005));
      script.push_back(wr_row(CSR_AF_ENABLE,  16'h0000));

      foreach (script[n]) begin
         if (script[n].is_write) begin
            drain();
            write_reg(script[n].reg_idx, script[n].reg_val);
         end else begin
            send_request(script[n].kind, script[n].code, script[n].frame,
                         script[n].pinned, script[n].want);
         end
      end
      pin_on = 1'b0;

      // Random part: eight phases, each with its own register settings,
      // the extremes of magazine size and delay among them. Most ticks land
      // on the scheduled shot frame so the magazine actually cycles.
      for (int p = 0; p < 8; p++) begin
         drain();
         case (p)
            0: begin en = 1'b1; bul = 8'h7F; dly = 16'h0000; prt = PORT_ONE; end
            1: begin en = 1'b1; bul = 8'h80; dly = 16'h0001; prt = 2'd2;     end
            2: begin
               en  = 1'b1;
               bul = 8'($urandom_range(0, 4));
               dly = 16'h7FFF;
               prt = 2'd0;
            end
            3: begin en = 1'b1; bul = 8'h01; dly = 16'h8000; prt = 2'd3;     end
            4: begin
               en  = 1'b0;
               bul = 8'($urandom);
               dly = 16'($urandom_range(0, 5));
               prt = 2'($urandom);
            end
            default: begin
               en  = ($urandom_range(0, 3) != 0);
               bul = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
               dly = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
               prt = 2'($urandom);
            end
         endcase
         // unused upper data bits get random values
         write_reg(CSR_AF_ENABLE,  {15'($urandom), en});
         write_reg(CSR_AF_BULLETS, {8'($urandom), bul});
         write_reg(CSR_AF_DELAY,   dly);
         write_reg(CSR_PORT_SEL,   {14'($urandom), prt});
         cur_frame = (p == 1) ? 32'hFFFF_FFF0 : 32'($urandom);

         for (int i = 0; i < 100; i++) begin
            // back-to-back requests against a long response hold-off
            if (p == 2 && i == 30) begin
               hold_rsp_req  = 1'b1;
               pressure_left = 30;
            end
            // one full pause mid-phase until every response is home
            if (p == 5 && i == 50) drain();

            if ($urandom_range(0, 49) == 0) cur_frame = $urandom;
            roll = $urandom_range(0, 99);
            code = 4'($urandom_range(0, 15));   // ignored on ticks
            if (roll < 45) begin
               kind  = REQ_TICK;
               frame = ($urandom_range(0, 3) != 0) ? next_shot
                                                   : cur_frame + 32'($urandom_range(0, 2));
            end else begin
               kind  = REQ_EVENT;
               frame = cur_frame + 32'($urandom_range(0, 1));
               if (roll < 60)      code = EV_PRESS_FIRE;
               else if (roll < 68) code = EV_RELEASE_FIRE;
               else if (roll < 95) code = 4'($urandom_range(EV_UP, EV_RELEASE_XY));
               else code = 4'($urandom_range(EV_RELEASE_FIRE + 1, EV_UNUSED_MAX));
            end
            cur_frame = frame;
            send_request(kind, code, frame, 1'b0, '0);

            // sender bursts with random gaps, none while under pressure
            if (pressure_left > 0) begin
               pressure_left--;
            end else if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               if (gap > 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(negedge clock);
               end
            end
         end
      end

      drain();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Hang guard, far beyond any correct run.
   initial begin
      #3000000;
      $display("Verification failed");
      $finish;
   end

endmodule
